// ===== rtl/msl_pkg.sv =====
`default_nettype none
package msl_pkg;

	localparam int WINDOW_MAX = 1024;
	localparam int CELL_COUNT = WINDOW_MAX + 1;

	localparam int VAL_W = 32;
	localparam int SUM_W = 48;
	localparam int KEY_W = SUM_W + 1;
	localparam int IDX_W = 17;
	localparam int RUN_W = 11;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// one deque entry: excluded position and its key f(j-1) - S(j)
	typedef struct packed {
		logic                    valid;
		logic [IDX_W-1:0]        index;
		logic signed [KEY_W-1:0] key;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_UPDATE
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t                op;
		logic                    flush;
		logic [IDX_W-1:0]        push_index;
		logic signed [KEY_W-1:0] push_key;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DROP,
		ST_UPDATE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/msl_cell.sv =====
`default_nettype none
module msl_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               seed,
	input  wire msl_pkg::cell_ctrl_t ctrl,
	input  wire msl_pkg::entry_t    next_entry,
	input  wire logic               prev_keep,
	output logic                    keep,
	output msl_pkg::entry_t         entry
);
	import msl_pkg::*;

	entry_t entry_q;
	logic   push;

	// entries with key <= the new key form a suffix of the row; they drop out in parallel
	assign keep  = entry_q.valid && !ctrl.flush && (entry_q.key > ctrl.push_key);
	// the new entry lands in the first cell past the kept prefix
	assign push  = !keep && prev_keep;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= {seed, {(IDX_W+KEY_W){1'b0}}};
		end else begin
			unique case (ctrl.op)
				CELL_HOLD: begin
				end
				CELL_SHIFT: begin
					entry_q <= next_entry;
				end
				CELL_UPDATE: begin
					if (push) begin
						entry_q.valid <= 1'b1;
						entry_q.index <= ctrl.push_index;
						entry_q.key   <= ctrl.push_key;
					end else begin
						entry_q.valid <= keep;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/msl_chain.sv =====
`default_nettype none
module msl_chain (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire msl_pkg::cell_ctrl_t ctrl,
	output msl_pkg::entry_t          head
);
	import msl_pkg::*;

	entry_t cell_entry [CELL_COUNT];
	logic   cell_keep  [CELL_COUNT];

	// cell 0 is the oldest entry; a shift moves every entry one cell toward it
	for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
		entry_t next_e;
		logic   prev_k;

		if (g == CELL_COUNT - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_mid
			assign next_e = cell_entry[g+1];
		end

		if (g == 0) begin : g_first
			assign prev_k = 1'b1;
		end else begin : g_rest
			assign prev_k = cell_keep[g-1];
		end

		msl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.seed       (g == 0),
			.ctrl       (ctrl),
			.next_entry (next_e),
			.prev_keep  (prev_k),
			.keep       (cell_keep[g]),
			.entry      (cell_entry[g])
		);
	end

	assign head = cell_entry[0];

endmodule
`default_nettype wire

// ===== rtl/max_sum_limited_run_select_core.sv =====
`default_nettype none
// Best selectable sum with a limited run of picked values. After every value the block
// returns the largest sum that can be picked from the sequence so far with no more than
// max_run consecutive values picked; start_req begins a new sequence with that value.
// The candidate deque lives in a row of WINDOW_MAX+1 cells, oldest entry in cell 0.
// An item passes accept, head check and update. The head check drops each stale head
// entry in turn, as the row shifts toward its head one cell per cycle, and the update
// waits while an earlier result is still stalled. Each position is dropped at most once,
// so drops average at most one per item; cutting max_run mid-sequence can force up to
// WINDOW_MAX drops on one item. A new item is accepted while the previous result still
// waits to be taken. max_run (0 acts as 1, above WINDOW_MAX acts as WINDOW_MAX) is to be
// written by the user only while idle; the block does not enforce it. It holds from the
// next value on. Sums saturate at 2^48-1. No clearing pass after reset.
module max_sum_limited_run_select_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic [msl_pkg::VAL_W-1:0]    value,
	input  wire logic                         start_req,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [msl_pkg::SUM_W-1:0]         best_sum,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [msl_pkg::RUN_W-1:0]    cfg_data
);
	import msl_pkg::*;

	state_t                  state_q, state_d;
	logic [RUN_W-1:0]        run_q;
	logic [SUM_W-1:0]        prefix_q;
	logic [SUM_W-1:0]        best_q;
	logic [IDX_W-1:0]        idx_q;
	logic [SUM_W-1:0]        sum_q;
	logic [IDX_W-1:0]        pos_q;
	logic signed [KEY_W-1:0] newkey_q;
	logic                    result_valid_q;
	logic [SUM_W-1:0]        result_q;

	cell_ctrl_t              ctrl;
	entry_t                  head;

	logic                    accept;
	logic                    out_busy;
	logic                    fire;
	logic [SUM_W-1:0]        base_prefix;
	logic [IDX_W-1:0]        base_idx;
	logic [SUM_W:0]          sum_wide;
	logic [SUM_W-1:0]        sum_sat;
	logic [IDX_W-1:0]        age;
	logic                    stale;
	logic signed [KEY_W:0]   head_total;
	logic signed [KEY_W:0]   best_ext;
	logic signed [KEY_W:0]   cand;
	logic [SUM_W-1:0]        cand_sat;
	logic [RUN_W-1:0]        run_eff;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign best_sum     = result_q;
	assign out_busy     = result_valid_q && result_stall;
	assign fire         = (state_q == ST_UPDATE) && !out_busy;

	always_comb begin
		if (cfg_data == '0) begin
			run_eff = RUN_W'(1);
		end else if (cfg_data > RUN_W'(WINDOW_MAX)) begin
			run_eff = RUN_W'(WINDOW_MAX);
		end else begin
			run_eff = cfg_data;
		end
	end

	assign base_prefix = start_req ? '0 : prefix_q;
	assign base_idx    = start_req ? '0 : idx_q;
	assign sum_wide    = {1'b0, base_prefix} + {{(SUM_W+1-VAL_W){1'b0}}, value};
	assign sum_sat     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

	// ages stay below the index wrap, so the modulo difference is the true age
	assign age   = pos_q - head.index;
	assign stale = head.valid && (age > {{(IDX_W-RUN_W){1'b0}}, run_q});

	assign head_total = $signed({2'b00, sum_q}) + $signed({head.key[KEY_W-1], head.key});
	assign best_ext   = $signed({2'b00, best_q});
	assign cand       = (head.valid && (head_total > best_ext)) ? head_total : best_ext;
	assign cand_sat   = (cand > $signed({2'b00, SUM_MAX})) ? SUM_MAX : cand[SUM_W-1:0];

	always_comb begin
		state_d         = state_q;
		ctrl.op         = CELL_HOLD;
		ctrl.flush      = 1'b0;
		ctrl.push_index = pos_q;
		ctrl.push_key   = newkey_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DROP;
					if (start_req) begin
						// empty the row and seed position zero with key zero
						ctrl.op         = CELL_UPDATE;
						ctrl.flush      = 1'b1;
						ctrl.push_index = '0;
						ctrl.push_key   = '0;
					end
				end
			end
			ST_DROP: begin
				if (stale) begin
					ctrl.op = CELL_SHIFT;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!out_busy) begin
					ctrl.op = CELL_UPDATE;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			run_q          <= RUN_W'(1);
			prefix_q       <= '0;
			best_q         <= '0;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				run_q <= run_eff;
			end
			if (accept && start_req) begin
				best_q <= '0;
			end
			if (fire) begin
				best_q         <= cand_sat;
				prefix_q       <= sum_q;
				idx_q          <= pos_q;
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= sum_sat;
			pos_q <= base_idx + IDX_W'(1);
		end
		if (state_q == ST_DROP) begin
			newkey_q <= $signed({1'b0, best_q}) - $signed({1'b0, sum_q});
		end
		if (fire) begin
			result_q <= cand_sat;
		end
	end

	msl_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.head   (head)
	);

	// the newest position is always live, so the row never ends up empty
	a_head_live: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> head.valid)
		else $error("deque empty after update");

	a_head_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> !stale)
		else $error("stale head entry used for result");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == ST_UPDATE)
		else $error("result raised outside update");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && out_busy) |=> (state_q == ST_UPDATE))
		else $error("update left while result request stalled");

endmodule
`default_nettype wire
